// ===== rtl/discrete_time_integrator_macros.svh =====
// Assertion macros for the discrete-time integrator.
// Included by the top level; depends on nothing else.
`ifndef DISCRETE_TIME_INTEGRATOR_MACROS_SVH
`define DISCRETE_TIME_INTEGRATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integrator check failed: same-cycle rule");

// Next-cycle implication, checked on every rising edge outside reset.
`define DTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integrator check failed: next-cycle rule");

`endif

// ===== rtl/dti_pkg.sv =====
// Shared constants for the discrete-time integrator: field widths,
// integration method codes and configuration register indexes. No dependencies.
package dti_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 31;
  localparam int METHOD_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Integration method codes
  localparam logic [METHOD_W-1:0] METH_FWD  = 2'd0;
  localparam logic [METHOD_W-1:0] METH_BWD  = 2'd1;
  localparam logic [METHOD_W-1:0] METH_TRAP = 2'd2;

  // Limit modes
  localparam logic MODE_WRAP = 1'b0;
  localparam logic MODE_SAT  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 31'd65536;

endpackage

// ===== rtl/discrete_time_integrator.sv =====
// Discrete-time integrator top level: input register, one multiply-add pass and
// a result register. Depends on dti_pkg and discrete_time_integrator_macros.svh.
//
// Takes one Q16.16 sample per clock cycle while out_stall is low and returns one
// result per sample. An accepted item waits in the input register and then moves
// to the result register, where out_stall can hold it. A result held
// by out_stall stalls the input once the input register also holds an item. The
// integrator state (last sample, last result, started flag) is updated in the
// same cycle that an item moves from the input register to the result
// register, so the next item already sees it; the single sample_time multiply
// followed by the clamp and limit logic is the path that sets the clock.
// Forward Euler, backward Euler and trapezoidal rules are chosen by the method
// register; the unused method code gives a zero result and, for an enabled
// item, keeps all state. Configuration writes are always taken (cfg_ready is
// tied high) and must only be issued while no item is in flight.
`include "discrete_time_integrator_macros.svh"

module discrete_time_integrator #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dti_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dti_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_enable,
  input  logic                                  in_clear_req,
  input  logic signed [dti_pkg::SAMPLE_W-1:0]   in_sample,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dti_pkg::SAMPLE_W-1:0]   out_result
);
  import dti_pkg::*;

  // Product width: unsigned gain times a 33-bit signed operand
  localparam int PW = GAIN_W + SAMPLE_W + 2;
  // Sum width: room for the wider of the data path and the start value
  localparam int SW = ((DATA_WIDTH > SAMPLE_W) ? DATA_WIDTH : SAMPLE_W) + 2;

  localparam logic signed [PW-1:0] TERM_MAX =
    {{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] TERM_MIN = ~TERM_MAX;
  localparam logic signed [SW-1:0] SUM_MAX =
    {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [SW-1:0] FRAC_MASK =
    {{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  // Configuration registers
  logic [METHOD_W-1:0]         method_r;
  logic                        limit_mode_r;
  logic [GAIN_W-1:0]           sample_time_r;
  logic [GAIN_W-1:0]           limit_level_r;
  logic signed [SAMPLE_W-1:0]  start_value_r;

  // Input register
  logic                        in_vld_r;
  logic                        in_en_r;
  logic                        in_clr_r;
  logic signed [SAMPLE_W-1:0]  in_sample_r;

  // Integrator state
  logic signed [SAMPLE_W-1:0]   last_sample_r, last_sample_nxt;
  logic signed [DATA_WIDTH-1:0] last_result_r, last_result_nxt;
  logic                         started_r, started_nxt;

  // Result register
  logic                         out_vld_r;
  logic signed [SAMPLE_W-1:0]   out_result_r, out_result_nxt;

  logic                         advance;

  // Datapath signals
  logic signed [SAMPLE_W:0]     operand;
  logic signed [PW-1:0]         product;
  logic signed [PW-1:0]         shifted;
  logic signed [PW-1:0]         term_clamped;
  logic signed [DATA_WIDTH-1:0] term;
  logic signed [SW-1:0]         sum_raw;
  logic signed [SW-1:0]         sum_clamped;
  logic signed [SW-1:0]         first_raw;
  logic signed [SW-1:0]         first_clamped;
  logic signed [SW-1:0]         limit_pos;
  logic signed [SW-1:0]         sat_step;
  logic signed [SW-1:0]         sat_val;
  logic signed [SW-1:0]         wrap_neg;
  logic signed [SW-1:0]         wrap_val;
  logic signed [SW-1:0]         y_final;
  logic                         method_ok;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r      <= METH_FWD;
      limit_mode_r  <= MODE_SAT;
      sample_time_r <= GAIN_RESET;
      limit_level_r <= GAIN_RESET;
      start_value_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_METHOD:      method_r      <= cfg_data[METHOD_W-1:0];
        CFG_LIMIT_MODE:  limit_mode_r  <= cfg_data[0];
        CFG_SAMPLE_TIME: sample_time_r <= cfg_data[GAIN_W-1:0];
        CFG_LIMIT_LEVEL: limit_level_r <= cfg_data[GAIN_W-1:0];
        CFG_START_VALUE: start_value_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // An item leaves the input register when the result register is free.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_en_r     <= in_enable;
      in_clr_r    <= in_clear_req;
      in_sample_r <= in_sample;
    end
  end

  // Operand select and the gain multiply.
  always_comb begin
    method_ok = 1'b1;
    unique case (method_r)
      METH_FWD:  operand = (SAMPLE_W+1)'(last_sample_r);
      METH_BWD:  operand = (SAMPLE_W+1)'(in_sample_r);
      METH_TRAP: operand = (SAMPLE_W+1)'(last_sample_r) + (SAMPLE_W+1)'(in_sample_r);
      default: begin
        operand   = '0;
        method_ok = 1'b0;
      end
    endcase
    product = PW'($signed({1'b0, sample_time_r})) * PW'(operand);
    // Arithmetic shift rounds toward minus infinity.
    shifted = (method_r == METH_TRAP) ? (product >>> (FRAC_BITS + 1))
                                      : (product >>> FRAC_BITS);
  end

  // Saturate the term and the running sum to the data width.
  always_comb begin
    if (shifted > TERM_MAX) begin
      term_clamped = TERM_MAX;
    end else if (shifted < TERM_MIN) begin
      term_clamped = TERM_MIN;
    end else begin
      term_clamped = shifted;
    end
    term = term_clamped[DATA_WIDTH-1:0];

    sum_raw = SW'(last_result_r) + SW'(term);
    if (sum_raw > SUM_MAX) begin
      sum_clamped = SUM_MAX;
    end else if (sum_raw < SUM_MIN) begin
      sum_clamped = SUM_MIN;
    end else begin
      sum_clamped = sum_raw;
    end
  end

  // First step adds the start value; later steps saturate or wrap.
  always_comb begin
    first_raw = sum_clamped + SW'(start_value_r);
    if (first_raw > SUM_MAX) begin
      first_clamped = SUM_MAX;
    end else if (first_raw < SUM_MIN) begin
      first_clamped = SUM_MIN;
    end else begin
      first_clamped = first_raw;
    end

    limit_pos = SW'($signed({1'b0, limit_level_r}));
    sat_step  = (sum_clamped >= limit_pos) ? limit_pos : sum_clamped;
    sat_val   = (sat_step <= -limit_pos) ? -limit_pos : sat_step;

    // Signed fraction, truncated toward zero.
    wrap_neg = -sum_clamped;
    wrap_val = (sum_clamped[SW-1]) ? -(wrap_neg & FRAC_MASK) : (sum_clamped & FRAC_MASK);

    priority if (!started_r) begin
      y_final = first_clamped;
    end else if (limit_mode_r == MODE_SAT) begin
      y_final = sat_val;
    end else begin
      y_final = wrap_val;
    end
  end

  // Next state and result for the item leaving the input register.
  always_comb begin
    last_sample_nxt = last_sample_r;
    last_result_nxt = last_result_r;
    started_nxt     = started_r;
    out_result_nxt  = '0;
    if (!in_en_r) begin
      last_sample_nxt = '0;
      last_result_nxt = '0;
      started_nxt     = 1'b0;
    end else if (method_ok) begin
      started_nxt     = 1'b1;
      out_result_nxt  = y_final[SAMPLE_W-1:0];
      last_result_nxt = y_final[DATA_WIDTH-1:0];
      if (method_r != METH_BWD) begin
        last_sample_nxt = in_sample_r;
      end
      if (in_clr_r && (limit_mode_r == MODE_SAT)) begin
        last_result_nxt = '0;
        if (method_r != METH_BWD) begin
          last_sample_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      last_result_r <= '0;
      started_r     <= 1'b0;
    end else if (advance) begin
      last_sample_r <= last_sample_nxt;
      last_result_r <= last_result_nxt;
      started_r     <= started_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_result = out_result_r;

  // A disabled item always yields zero and leaves the integrator unstarted.
  `DTI_ASSERT_NEXT(a_disable_zero, clk, rst_n, advance && !in_en_r, out_result_r == '0)
  `DTI_ASSERT_NEXT(a_disable_unstarted, clk, rst_n, advance && !in_en_r, !started_r)
  // The input side only stalls while holding an item.
  `DTI_ASSERT_NOW(a_stall_needs_item, clk, rst_n, in_stall, in_vld_r)
  // A result still waiting to be taken is never overwritten.
  `DTI_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_vld_r && out_stall, !advance)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the discrete-time integrator: a directed pass over
// the extremes, then random phases, each with its own configuration.
// Depends on dti_pkg and the discrete_time_integrator RTL.
module testbench;
  import dti_pkg::*;

  // Fixed-point format and limits of the 32-bit internal word
  localparam int FRAC_BITS = 16;
  localparam longint FRAC_MASK = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // Codes that the package leaves unnamed
  localparam logic [METHOD_W-1:0] METH_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef enum {IDLE_NONE, IDLE_FULL, IDLE_LIGHT} idle_mode_t;

  typedef struct {
    logic enable;
    logic clear_req;
    logic signed [SAMPLE_W-1:0] sample;
  } sample_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_METHOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_enable = 1'b0;
  logic in_clear_req = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_result;

  // Shadow copy of the configuration registers
  logic [METHOD_W-1:0] cfg_meth = METH_FWD;
  logic cfg_mode = MODE_SAT;
  logic [GAIN_W-1:0] cfg_ts = GAIN_RESET;
  logic [GAIN_W-1:0] cfg_lim = GAIN_RESET;
  logic signed [SAMPLE_W-1:0] cfg_start = '0;

  // Integrator state as the predictor sees it
  longint prev_sample = 0;
  longint prev_result = 0;
  logic primed = 1'b0;

  sample_item_t pending_samples[$];
  logic signed [SAMPLE_W-1:0] expected_results[$];

  idle_mode_t idle_mode = IDLE_FULL;
  int mismatch_count = 0;
  int results_seen = 0;
  int gap_left = 0;
  int wait_left = 0;
  int hold_left = 0;

  discrete_time_integrator i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_enable    (in_enable),
    .in_clear_req (in_clear_req),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result)
  );

  // Clock, period 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // Advances the integrator by one item and returns the output it gives.
  function automatic logic signed [SAMPLE_W-1:0] integrate_step(
    logic en, logic clr, logic signed [SAMPLE_W-1:0] u);
    longint ts_l;
    longint u_l;
    longint term;
    longint y;
    longint lvl;
    ts_l = cfg_ts;
    u_l = u;
    if (!en) begin
      prev_sample = 0;
      prev_result = 0;
      primed = 1'b0;
      return '0;
    end
    // The product is exact in 64 bits; the arithmetic shift rounds toward minus infinity.
    case (cfg_meth)
      METH_FWD: term = (ts_l * prev_sample) >>> FRAC_BITS;
      METH_BWD: term = (ts_l * u_l) >>> FRAC_BITS;
      METH_TRAP: term = (ts_l * (prev_sample + u_l)) >>> (FRAC_BITS + 1);
      default: return '0;
    endcase
    y = clamp_word(prev_result + clamp_word(term));

    // The first step adds the initial value and skips limiting.
    if (!primed) begin
      y = clamp_word(y + longint'(cfg_start));
      primed = 1'b1;
    end else if (cfg_mode == MODE_SAT) begin
      lvl = cfg_lim;
      if (y >= lvl) y = lvl;
      if (y <= -lvl) y = -lvl;
    end else begin
      // Signed remainder modulo one, truncated toward zero.
      y = (y >= 0) ? (y & FRAC_MASK) : -((-y) & FRAC_MASK);
    end

    if (cfg_meth != METH_BWD) prev_sample = u_l;
    prev_result = y;
    if (clr && cfg_mode == MODE_SAT) begin
      if (cfg_meth != METH_BWD) prev_sample = 0;
      prev_result = 0;
    end
    return y[SAMPLE_W-1:0];
  endfunction

  // Number of idle cycles one side spends before its next item.
  function automatic int idle_draw();
    case (idle_mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 14);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  task automatic push_item(logic en, logic clr, logic signed [SAMPLE_W-1:0] s);
    sample_item_t it;
    it.enable = en;
    it.clear_req = clr;
    it.sample = s;
    pending_samples.push_back(it);
  endtask

  // Writes one register and mirrors it once the write is taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_METHOD: cfg_meth = data[METHOD_W-1:0];
      CFG_LIMIT_MODE: cfg_mode = data[0];
      CFG_SAMPLE_TIME: cfg_ts = data[GAIN_W-1:0];
      CFG_LIMIT_LEVEL: cfg_lim = data[GAIN_W-1:0];
      CFG_START_VALUE: cfg_start = data;
      default: ;
    endcase
  endtask

  // Holds the sender back until every queued item has come out of the block.
  // The check runs at the falling edge, when the clocked processes have settled.
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: presents queued items, with a random gap after each accepted one.
  always @(posedge clk) begin
    sample_item_t nxt;
    logic take;
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      take = in_valid && !in_stall;
      nxt_valid = in_valid && !take;
      if (take) begin
        expected_results.push_back(integrate_step(in_enable, in_clear_req, in_sample));
        gap_left = idle_draw();
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() != 0) begin
          nxt = pending_samples.pop_front();
          in_enable <= nxt.enable;
          in_clear_req <= nxt.clear_req;
          in_sample <= nxt.sample;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: checks each result against the oldest prediction and stalls at random.
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_result);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_result !== want) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, out_result);
            mismatch_count++;
          end
        end
        results_seen++;
        // Two long hold-offs so that the block fills up and stalls its input.
        if (results_seen == 200 || results_seen == 700) hold_left = 100;
        wait_left = idle_draw();
      end
      out_stall <= (hold_left > 0) || (wait_left > 0);
      if (hold_left > 0) hold_left--;
      else if (wait_left > 0) wait_left--;
    end
  end

  // Stimulus: directed extremes first, then random phases.
  initial begin
    logic [METHOD_W-1:0] mc;
    logic md;
    logic [CFG_DATA_W-1:0] word;
    logic signed [SAMPLE_W-1:0] s;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Forward Euler, saturate, unit gain and limit: extreme samples and a clear.
    push_item(1'b1, 1'b0, 32'sh7FFFFFFF);
    push_item(1'b1, 1'b0, 32'sh80000000);
    push_item(1'b1, 1'b1, 32'sh00000000);
    push_item(1'b0, 1'b0, 32'sh7FFFFFFF);
    push_item(1'b1, 1'b0, 32'shFFFFFFFF);
    push_item(1'b1, 1'b0, 32'sh00000001);
    drain();

    // Backward Euler at full gain, limit and initial value: every term saturates.
    write_reg(CFG_METHOD, {30'd0, METH_BWD});
    write_reg(CFG_SAMPLE_TIME, 32'h7FFFFFFF);
    write_reg(CFG_LIMIT_LEVEL, 32'h7FFFFFFF);
    write_reg(CFG_START_VALUE, 32'h7FFFFFFF);
    push_item(1'b0, 1'b0, 32'sh00000000);
    push_item(1'b1, 1'b0, 32'sh7FFFFFFF);
    push_item(1'b1, 1'b0, 32'sh7FFFFFFF);
    push_item(1'b1, 1'b1, 32'sh80000000);
    push_item(1'b1, 1'b0, 32'sh80000000);
    drain();

    // A limit of zero forces every later output to zero.
    write_reg(CFG_LIMIT_LEVEL, 32'h00000000);
    push_item(1'b1, 1'b0, 32'sh00012345);
    push_item(1'b1, 1'b0, -32'sh00012345);
    drain();

    // Trapezoidal in wrap mode from the most negative initial value; clears are ignored.
    write_reg(CFG_METHOD, {30'd0, METH_TRAP});
    write_reg(CFG_LIMIT_MODE, {31'd0, MODE_WRAP});
    write_reg(CFG_SAMPLE_TIME, 32'h00010000);
    write_reg(CFG_START_VALUE, 32'h80000000);
    push_item(1'b0, 1'b0, 32'sh00000000);
    push_item(1'b1, 1'b1, 32'sh00030000);
    push_item(1'b1, 1'b1, 32'sh7FFFFFFF);
    push_item(1'b1, 1'b0, 32'sh80000000);
    push_item(1'b1, 1'b0, -32'sh00028000);
    drain();

    // Zero gain, then the unused method code.
    write_reg(CFG_SAMPLE_TIME, 32'h00000000);
    push_item(1'b1, 1'b0, 32'sh7FFFFFFF);
    drain();
    write_reg(CFG_METHOD, {30'd0, METH_SPARE});
    push_item(1'b1, 1'b0, 32'sh00000005);
    push_item(1'b0, 1'b0, 32'sh00000005);
    push_item(1'b1, 1'b1, -32'sh00000005);

    // Random phases cover every method in both limit modes.
    for (int p = 0; p < 12; p++) begin
      drain();
      case (p % 3)
        0: idle_mode = IDLE_FULL;
        1: idle_mode = IDLE_LIGHT;
        default: idle_mode = IDLE_NONE;
      endcase
      case (p % 3)
        0: mc = METH_FWD;
        1: mc = METH_BWD;
        default: mc = METH_TRAP;
      endcase
      if (p == 10) mc = METH_SPARE;
      md = ((p / 3) % 2 == 0) ? MODE_SAT : MODE_WRAP;

      // Unused upper bits of a register are sometimes set.
      word = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      word[METHOD_W-1:0] = mc;
      write_reg(CFG_METHOD, word);
      word = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      word[0] = md;
      write_reg(CFG_LIMIT_MODE, word);
      case ($urandom_range(0, 5))
        0: word = 32'h7FFFFFFF;
        1: word = 32'h00000000;
        2: word = $urandom;
        default: word = $urandom_range(32'h800, 32'h18000);
      endcase
      write_reg(CFG_SAMPLE_TIME, word);
      case ($urandom_range(0, 5))
        0: word = 32'h7FFFFFFF;
        1: word = 32'h00000000;
        2: word = $urandom;
        default: word = $urandom_range(32'h100, 32'h80000);
      endcase
      write_reg(CFG_LIMIT_LEVEL, word);
      case ($urandom_range(0, 5))
        0: word = 32'h7FFFFFFF;
        1: word = 32'h80000000;
        2: word = $urandom;
        default: word = $urandom_range(0, 32'h40000) - 32'h20000;
      endcase
      write_reg(CFG_START_VALUE, word);
      if (p % 4 == 3) write_reg(CFG_IDX_SPARE, $urandom);

      // Mostly long enabled runs; the last phase is noise with frequent clears.
      for (int k = 0; k < 120; k++) begin
        case ($urandom_range(0, 7))
          0: s = $urandom;
          1: begin
            case ($urandom_range(0, 3))
              0: s = 32'sh7FFFFFFF;
              1: s = 32'sh80000000;
              2: s = 32'sh00000000;
              default: s = 32'shFFFFFFFF;
            endcase
          end
          default: s = $urandom_range(0, 32'h40000) - 32'h20000;
        endcase
        if (p == 11)
          push_item($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, s);
        else
          push_item($urandom_range(0, 19) != 0, $urandom_range(0, 15) == 0, s);
      end
    end

    // Wait for the last results, with a limit, then let the pipeline settle.
    while (pending_samples.size() != 0 || in_valid) @(negedge clk);
    n = 0;
    while (expected_results.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results missing, expected %h, actual none",
               $time, expected_results.size(), expected_results[0]);
      mismatch_count++;
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #20000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
